>>> src/positional_list_store_macros.svh
// Assertion macros shared by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Checked only outside reset.
`define PLS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLS_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pls_pkg.sv
// Shared types and constants of the positional list store.
package pls_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 12;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 11;
  localparam int COUNT_W  = 11;
  // Wide enough to compare positions and counts up to 4097 without wrap.
  localparam int CMP_W    = 14;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_PRED   = 3'd4,
    ACT_SUCC   = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_NOP    = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PICK_OWN   = 2'd0,
    PICK_LEFT  = 2'd1,
    PICK_RIGHT = 2'd2
  } pick_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic  shift_ins;
    logic  shift_del;
    logic  by_pos;
    logic  by_val;
    pick_t pick;
  } cell_ctrl_t;

endpackage

>>> src/pls_ifs.sv
// Request and response channel interfaces of the positional list store.
interface pls_req_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic [FPOS_W-1:0]         found_position;
  logic [COUNT_W-1:0]        count_after;
  logic                      is_empty;

  modport source (output valid, status, out_value, found_position, count_after, is_empty,
                  input ready);
  modport sink (input valid, status, out_value, found_position, count_after, is_empty,
                output ready);
endinterface

>>> src/pls_cell.sv
// One element cell of the list chain: holds an element, shifts and compares.
module pls_cell import pls_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 11
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  flag,
  output logic [DATA_WIDTH-1:0] sel_data
);

  logic [CMP_W-1:0] place;
  logic             pos_hit;
  logic             pos_after;
  logic             live;
  logic             val_hit;

  assign place     = CMP_W'(INDEX) + CMP_W'(1);
  assign pos_hit   = place == CMP_W'(pos);
  assign pos_after = place > CMP_W'(pos);
  assign live      = CMP_W'(INDEX) < CMP_W'(count);
  assign val_hit   = live && (data == key);
  assign flag      = (ctrl.by_pos && pos_hit) || (ctrl.by_val && val_hit);

  always_comb begin
    unique case (ctrl.pick)
      PICK_LEFT:  sel_data = left_data;
      PICK_RIGHT: sel_data = right_data;
      default:    sel_data = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_ins) begin
      if (pos_hit) begin
        data <= key;
      end else if (pos_after) begin
        data <= left_data;
      end
    end else if (ctrl.shift_del && (pos_hit || pos_after)) begin
      data <= right_data;
    end
  end

endmodule

>>> src/pls_group.sv
// Registered first-hit stage over a group of cells, chained toward group zero.
module pls_group import pls_pkg::*; #(
  parameter int GW         = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     shift,
  input  logic [GW-1:0]            flags,
  input  logic [DATA_WIDTH-1:0]    sel_data [GW],
  input  logic                     next_hit,
  input  logic [$clog2(GW)-1:0]    next_off,
  input  logic [DATA_WIDTH-1:0]    next_data,
  output logic                     hit,
  output logic [$clog2(GW)-1:0]    off,
  output logic [DATA_WIDTH-1:0]    data
);

  localparam int OFF_W = $clog2(GW);

  logic                  enc_hit;
  logic [OFF_W-1:0]      enc_off;
  logic [DATA_WIDTH-1:0] enc_data;

  // Walk from the top so the lowest flagged cell wins.
  always_comb begin
    enc_hit  = 1'b0;
    enc_off  = '0;
    enc_data = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (flags[j]) begin
        enc_hit  = 1'b1;
        enc_off  = OFF_W'(j);
        enc_data = sel_data[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit  <= enc_hit;
      off  <= enc_off;
      data <= enc_data;
    end else if (shift) begin
      hit  <= next_hit;
      off  <= next_off;
      data <= next_data;
    end
  end

endmodule

>>> src/positional_list_store.sv
// Positional list store: a packed list held in a chain of element cells.
//
// Requests arrive on req (action, position, value); one response per request
// leaves on rsp (status, out_value, found_position, count_after, is_empty).
// Both are valid/ready channels; an item moves when valid and ready are high.
// The block works on one item at a time: req.ready is high while it is idle.
// After acceptance the compare state compares all cells at once and performs any
// insert or delete shift; the per-group first hits are registered there.
// Insert, clear, no-op and rejected requests then go straight to the done
// state. Get, delete, locate, predecessor and successor first scan the
// registered group results, one group of 32 cells per cycle, stopping at the
// first hit or at the last group, so at most CAPACITY/32 - 1 groups (31 at
// 1024 entries) are passed before it. The next request is taken the cycle
// after the response is loaded, so a new request is never accepted before
// the previous one has its response loaded.
// A finished response waits in the output register while rsp.ready is low;
// the block holds its next result until the register is free.
// Reset empties the list; element contents are not cleared and need no
// clearing pass, since only positions below the count are ever read.
`include "positional_list_store_macros.svh"

module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  pls_req_if.sink req,
  pls_rsp_if.source rsp
);

  localparam int GW     = (CAPACITY < 32) ? 2 ** $clog2(CAPACITY) : 32;
  localparam int OFF_W  = $clog2(GW);
  localparam int NG     = (CAPACITY + GW - 1) / GW;
  localparam int SLOTS  = NG * GW;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SCAN_W = $clog2(NG + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  action_t               op_action;
  logic [POS_W-1:0]      op_pos;
  logic [DATA_WIDTH-1:0] op_key;
  logic [CNT_W-1:0]      count;
  logic [SCAN_W-1:0]     scan;

  status_t               res_status;
  logic [VALUE_W-1:0]    res_value;
  logic [FPOS_W-1:0]     res_fpos;

  logic                  out_valid;
  status_t               out_status;
  logic [VALUE_W-1:0]    out_value;
  logic [FPOS_W-1:0]     out_fpos;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_empty;

  logic signed [63:0]    in_ext;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic                  pos_in;
  logic                  pos_ins;
  logic                  full;
  logic                  ins_ok;
  logic                  del_ok;
  logic                  op_by_pos;
  logic                  last_scan;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [SLOTS-1:0]      flag_pad;
  logic [DATA_WIDTH-1:0] sel_pad [SLOTS];

  logic                  grp_hit  [NG];
  logic [OFF_W-1:0]      grp_off  [NG];
  logic [DATA_WIDTH-1:0] grp_data [NG];

  logic [CMP_W-1:0]      head_k;
  logic signed [63:0]    head_ext;

  assign in_ext  = 64'(req.value);
  assign pos_w   = CMP_W'(op_pos);
  assign cnt_w   = CMP_W'(count);
  assign pos_in  = (op_pos != '0) && (pos_w <= cnt_w);
  assign pos_ins = (op_pos != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign full    = count == CNT_W'(CAPACITY);
  assign ins_ok  = (op_action == ACT_INSERT) && pos_ins && !full;
  assign del_ok  = (op_action == ACT_DELETE) && pos_in;
  assign op_by_pos = ((op_action == ACT_DELETE) || (op_action == ACT_GET)) && pos_in;
  assign last_scan = scan == SCAN_W'(NG - 1);

  always_comb begin
    ctrl.shift_ins = (state == S_CMP) && ins_ok;
    ctrl.shift_del = (state == S_CMP) && del_ok;
    ctrl.by_pos    = op_by_pos;
    ctrl.by_val    = (op_action == ACT_LOCATE) || (op_action == ACT_PRED) ||
                     (op_action == ACT_SUCC);
    if (op_action == ACT_PRED) begin
      ctrl.pick = PICK_LEFT;
    end else if (op_action == ACT_SUCC) begin
      ctrl.pick = PICK_RIGHT;
    end else begin
      ctrl.pick = PICK_OWN;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pls_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (op_pos),
      .key        (op_key),
      .count      (count),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .flag       (flag_pad[i]),
      .sel_data   (sel_pad[i])
    );
  end

  for (genvar s = CAPACITY; s < SLOTS; s++) begin : g_pad
    assign flag_pad[s] = 1'b0;
    assign sel_pad[s]  = '0;
  end

  for (genvar g = 0; g < NG; g++) begin : g_group
    logic [DATA_WIDTH-1:0] grp_sel [GW];
    logic                  nxt_hit;
    logic [OFF_W-1:0]      nxt_off;
    logic [DATA_WIDTH-1:0] nxt_data;

    for (genvar j = 0; j < GW; j++) begin : g_sel
      assign grp_sel[j] = sel_pad[g * GW + j];
    end

    if (g == NG - 1) begin : g_tail
      assign nxt_hit  = 1'b0;
      assign nxt_off  = '0;
      assign nxt_data = '0;
    end else begin : g_link
      assign nxt_hit  = grp_hit[g + 1];
      assign nxt_off  = grp_off[g + 1];
      assign nxt_data = grp_data[g + 1];
    end

    pls_group #(
      .GW         (GW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_group (
      .clk       (clk),
      .load      (state == S_CMP),
      .shift     (state == S_SCAN),
      .flags     (flag_pad[g * GW +: GW]),
      .sel_data  (grp_sel),
      .next_hit  (nxt_hit),
      .next_off  (nxt_off),
      .next_data (nxt_data),
      .hit       (grp_hit[g]),
      .off       (grp_off[g]),
      .data      (grp_data[g])
    );
  end

  assign head_k   = (CMP_W'(scan) << OFF_W) + CMP_W'(grp_off[0]);
  assign head_ext = 64'(signed'(grp_data[0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_action <= action_t'(req.action);
            op_pos    <= req.position;
            op_key    <= in_ext[DATA_WIDTH-1:0];
            state     <= S_CMP;
          end
        end
        S_CMP: begin
          res_value <= '0;
          res_fpos  <= '0;
          scan      <= '0;
          state     <= S_DONE;
          unique case (op_action)
            ACT_INSERT: begin
              if (!pos_ins) begin
                res_status <= ST_BADPOS;
              end else if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                count      <= count + CNT_W'(1);
              end
            end
            ACT_DELETE, ACT_GET: begin
              res_status <= pos_in ? ST_OK : ST_BADPOS;
              if (pos_in) begin
                state <= S_SCAN;
              end
              if (del_ok) begin
                count <= count - CNT_W'(1);
              end
            end
            ACT_LOCATE, ACT_PRED, ACT_SUCC: begin
              res_status <= ST_NOTFOUND;
              state      <= S_SCAN;
            end
            ACT_CLEAR: begin
              res_status <= ST_OK;
              count      <= '0;
            end
            ACT_NOP: begin
              res_status <= ST_OK;
            end
          endcase
        end
        S_SCAN: begin
          scan <= scan + SCAN_W'(1);
          if (grp_hit[0] || last_scan) begin
            state <= S_DONE;
          end
          if (grp_hit[0]) begin
            unique case (op_action)
              ACT_DELETE, ACT_GET: begin
                res_value <= head_ext[VALUE_W-1:0];
              end
              ACT_LOCATE: begin
                res_status <= ST_OK;
                res_fpos   <= FPOS_W'(head_k + CMP_W'(1));
              end
              ACT_PRED: begin
                if (head_k != '0) begin
                  res_status <= ST_OK;
                  res_value  <= head_ext[VALUE_W-1:0];
                end
              end
              ACT_SUCC: begin
                if (head_k + CMP_W'(1) < cnt_w) begin
                  res_status <= ST_OK;
                  res_value  <= head_ext[VALUE_W-1:0];
                end
              end
              ACT_INSERT, ACT_CLEAR, ACT_NOP: begin
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response payload; loaded together with out_valid in the final state.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_fpos   <= res_fpos;
      out_count  <= COUNT_W'(count);
      out_empty  <= count == '0;
    end
  end

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.out_value      = out_value;
  assign rsp.found_position = out_fpos;
  assign rsp.count_after    = out_count;
  assign rsp.is_empty       = out_empty;

  // The list never holds more elements than it has cells.
  `PLS_ASSERT_RST(a_count_bound, count <= CNT_W'(CAPACITY), "element count beyond capacity")
  // A valid get or delete position always lies in some group of the scan.
  `PLS_ASSERT_RST(a_pos_scan_hits, (state == S_SCAN && op_by_pos && last_scan) |-> grp_hit[0], "positional scan ended without a hit")
  // The count changes only on the edge that closes the compare cycle.
  `PLS_ASSERT_RST(a_count_only_cmp, ($past(state) != S_CMP && !$past(rst)) |-> $stable(count), "element count changed outside compare")

endmodule

>>> test/positional_list_store_checker.sv
// Checker for the positional list store: predicts every reply and compares it.
module positional_list_store_checker import pls_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input logic clk,
  input logic rst,
  pls_req_if  req,
  pls_rsp_if  rsp,
  output int  failures,
  output int  pending
);

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [FPOS_W-1:0]    fpos;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } list_reply_t;

  logic [VALUE_W-1:0] slots [CAPACITY];
  int                 list_len;
  list_reply_t        expected_replies [$];

  // Applies one request to the local copy of the list and returns its reply.
  function automatic list_reply_t apply_request(action_t act, int pos, logic [VALUE_W-1:0] val);
    list_reply_t r;
    int          hit;
    int          i;
    r = '0;
    r.status = ST_OK;
    // Index of the first element equal to the value, list_len when absent.
    hit = 0;
    while (hit < list_len && slots[hit] != val) hit++;
    case (act)
      ACT_INSERT: begin
        if (pos == 0 || pos > list_len + 1) begin
          r.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i >= pos; i--) slots[i] = slots[i-1];
          slots[pos-1] = val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos == 0 || pos > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = slots[pos-1];
          for (i = pos - 1; i < list_len - 1; i++) slots[i] = slots[i+1];
          list_len--;
        end
      end
      ACT_GET: begin
        if (pos == 0 || pos > list_len) r.status = ST_BADPOS;
        else r.value = slots[pos-1];
      end
      ACT_LOCATE: begin
        if (hit < list_len) r.fpos = FPOS_W'(hit + 1);
        else r.status = ST_NOTFOUND;
      end
      ACT_PRED: begin
        if (hit < list_len && hit > 0) r.value = slots[hit-1];
        else r.status = ST_NOTFOUND;
      end
      ACT_SUCC: begin
        if (hit + 1 < list_len) r.value = slots[hit+1];
        else r.status = ST_NOTFOUND;
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      list_len = 0;
      expected_replies.delete();
    end else begin
      if (req.valid && req.ready)
        expected_replies.push_back(apply_request(action_t'(req.action), int'(req.position),
                                                 req.value));
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with no request outstanding: expected none, got status %0d",
                   $time, rsp.status, " value %0h pos %0d count %0d empty %0b",
                   rsp.out_value, rsp.found_position, rsp.count_after, rsp.is_empty);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("out_value", want.value, rsp.out_value);
          check_field("found_position", 32'(want.fpos), 32'(rsp.found_position));
          check_field("count_after", 32'(want.count), 32'(rsp.count_after));
          check_field("is_empty", 32'(want.empty), 32'(rsp.is_empty));
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> test/positional_list_store_tb.sv
// Testbench top for the positional list store: clock, reset, stimulus and verdict.
module positional_list_store_tb import pls_pkg::*; ();

  localparam int CAPACITY   = 1024;
  localparam int STALL_LEN  = 300;
  // Longest quiet stretch of a good run is the long receiver hold-off plus a
  // full-depth scan; this is several times that.
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   idle_cycles;
  int   len_model;
  bit   gaps_on;
  bit   hold_request;

  pls_req_if req ();
  pls_rsp_if rsp ();

  positional_list_store uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  positional_list_store_checker #(.CAPACITY(CAPACITY)) reply_chk (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly small values so that searches hit, with the extremes mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(0, 10)) - 32'd5;
    endcase
  endfunction

  // Offers one item and returns at the edge where it is accepted.
  task automatic offer(input action_t act, input int pos, input logic [31:0] val);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.action   <= act;
    req.position <= pos[POS_W-1:0];
    req.value    <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // Track the list length only to aim positions at the valid range.
    case (act)
      ACT_INSERT: if (pos >= 1 && pos <= len_model + 1 && len_model < CAPACITY) len_model++;
      ACT_DELETE: if (pos >= 1 && pos <= len_model) len_model--;
      ACT_CLEAR:  len_model = 0;
      default: ;
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = STALL_LEN;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= !(gaps_on && $urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("positional_list_store test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          roll;
    logic [31:0] head_val;
    logic [31:0] tail_val;
    idle_cycles  = 0;
    len_model    = 0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    rst          = 1'b1;
    req.valid    <= 1'b0;
    req.action   <= ACT_NOP;
    req.position <= '0;
    req.value    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list reads, bad positions, extremes and every action.
    offer(ACT_PRED, 1, 32'd0);
    offer(ACT_SUCC, 1, 32'd0);
    offer(ACT_GET, 1, 32'd0);
    offer(ACT_DELETE, 0, 32'd0);
    offer(ACT_INSERT, 0, 32'd7);
    offer(ACT_INSERT, 2, 32'd7);
    offer(ACT_INSERT, 1, 32'h8000_0000);
    offer(ACT_INSERT, 2, 32'h7fff_ffff);
    offer(ACT_INSERT, 1, 32'hffff_ffff);
    offer(ACT_INSERT, 2, 32'd0);
    offer(ACT_LOCATE, 0, 32'h7fff_ffff);
    offer(ACT_LOCATE, 0, 32'd5);
    offer(ACT_PRED, 0, 32'hffff_ffff);
    offer(ACT_PRED, 0, 32'h7fff_ffff);
    offer(ACT_SUCC, 0, 32'h7fff_ffff);
    offer(ACT_SUCC, 0, 32'hffff_ffff);
    offer(ACT_GET, 4, 32'd0);
    offer(ACT_GET, 5, 32'd0);
    offer(ACT_GET, 4095, 32'd0);
    offer(ACT_DELETE, 2, 32'd0);
    offer(ACT_DELETE, 3, 32'd0);
    offer(ACT_NOP, 4095, 32'hffff_ffff);
    offer(ACT_CLEAR, 0, 32'd0);
    offer(ACT_GET, 1, 32'd0);

    // Random operations on short lists with values drawn from a small pool.
    for (n = 0; n < 400; n++) begin
      if (n == 150) hold_request = 1'b1;
      roll = $urandom_range(0, 99);
      if (len_model > 40 && roll < 50) roll = 40;
      if (len_model == 0 && roll >= 35 && roll < 60) roll = 0;
      if (roll < 35)
        offer(ACT_INSERT, $urandom_range(1, len_model + 1), pick_value());
      else if (roll < 50)
        offer(ACT_DELETE, $urandom_range(1, len_model), $urandom);
      else if (roll < 60)
        offer(ACT_GET, $urandom_range(1, len_model), $urandom);
      else if (roll < 70)
        offer(ACT_LOCATE, $urandom_range(0, 4095), pick_value());
      else if (roll < 78)
        offer(ACT_PRED, $urandom_range(0, 4095), pick_value());
      else if (roll < 86)
        offer(ACT_SUCC, $urandom_range(0, 4095), pick_value());
      else if (roll < 94)
        offer(action_t'(ACTION_W'($urandom_range(0, 7))), $urandom_range(0, 4095), $urandom);
      else if (roll < 96)
        offer(ACT_CLEAR, $urandom_range(0, 4095), $urandom);
      else
        offer(action_t'(ACTION_W'($urandom_range(0, 2))),
              $urandom_range(0, 1) ? 0 : len_model + 2 + $urandom_range(0, 3), pick_value());
    end

    // Fill the store to capacity; the first element stays at position one.
    offer(ACT_CLEAR, 0, 32'd0);
    gaps_on = 1'b0;
    head_val = $urandom;
    offer(ACT_INSERT, 1, head_val);
    for (n = 1; n < CAPACITY - 1; n++) begin
      if (n == CAPACITY / 2) gaps_on = 1'b1;
      offer(ACT_INSERT, $urandom_range(2, len_model + 1), $urandom);
    end
    tail_val = $urandom;
    offer(ACT_INSERT, len_model + 1, tail_val);
    offer(ACT_INSERT, 1, $urandom);
    offer(ACT_INSERT, CAPACITY + 1, $urandom);
    offer(ACT_INSERT, CAPACITY + 2, $urandom);
    offer(ACT_GET, CAPACITY, 32'd0);
    offer(ACT_GET, CAPACITY + 1, 32'd0);
    offer(ACT_LOCATE, 0, tail_val);
    offer(ACT_LOCATE, 0, $urandom);
    offer(ACT_PRED, 0, head_val);
    offer(ACT_SUCC, 0, head_val);
    offer(ACT_PRED, 0, tail_val);
    offer(ACT_SUCC, 0, tail_val);

    // Shrink again with searches and reads spread through the list.
    for (n = 0; n < 80; n++) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) offer(ACT_DELETE, $urandom_range(1, len_model), $urandom);
      else if (roll < 8) offer(ACT_GET, $urandom_range(1, len_model), $urandom);
      else offer(ACT_LOCATE, 0, $urandom_range(0, 1) ? tail_val : $urandom);
    end
    offer(ACT_CLEAR, 0, 32'd0);
    req.valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("positional_list_store test passed");
    end else begin
      $display("positional_list_store test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/pls_pkg.sv
src/pls_ifs.sv
src/pls_cell.sv
src/pls_group.sv
src/positional_list_store.sv
test/positional_list_store_checker.sv
test/positional_list_store_tb.sv
